@@ src/swr_pkg.sv @@
// Package for the square window rotator: field widths, command codes and the job word.
`timescale 1ns / 1ps
package swr_pkg;

  localparam int CMD_W    = 2;
  localparam int COORD_W  = 7;
  localparam int RADIUS_W = 5;
  localparam int CELL_W   = 13;

  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [RADIUS_W-1:0] radius_t;
  typedef logic [CELL_W-1:0]   cell_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT   = 2'd0,
    CMD_ROTATE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_ROTATE,
    JOB_READ,
    JOB_REPLY
  } job_op_t;

  typedef struct packed {
    job_op_t op;
    coord_t  row_lo;
    coord_t  row_hi;
    coord_t  col_lo;
    coord_t  col_hi;
    coord_t  ctr_row;
    coord_t  ctr_col;
    logic    dir;
    logic    status;
  } job_t;

  localparam coord_t GRID_SIZE_RESET = 7'd64;

endpackage

@@ src/swr_if.sv @@
// Handshake channels for the square window rotator: command words in, result words out.
`timescale 1ns / 1ps
interface swr_in_if;
  logic                         valid;
  logic                         ready;
  logic [swr_pkg::CMD_W-1:0]    cmd;
  logic [swr_pkg::COORD_W-1:0]  center_row;
  logic [swr_pkg::COORD_W-1:0]  center_col;
  logic [swr_pkg::RADIUS_W-1:0] radius;
  logic                         direction;

  modport source (output valid, cmd, center_row, center_col, radius, direction, input ready);
  modport sink   (input valid, cmd, center_row, center_col, radius, direction, output ready);
endinterface

interface swr_out_if;
  logic                       valid;
  logic                       ready;
  logic [swr_pkg::CELL_W-1:0] cell_value;
  logic                       status;

  modport source (output valid, cell_value, status, input ready);
  modport sink   (input valid, cell_value, status, output ready);
endinterface

@@ src/swr_front.sv @@
// Front end: accepts command words, checks bounds and turns them into job words.
`timescale 1ns / 1ps
module swr_front #(
  parameter int MAX_SIDE = 64
) (
  input  swr_pkg::coord_t grid_size,
  swr_in_if.sink          items,
  input  logic            full,
  output logic            push,
  output swr_pkg::job_t   job
);

  localparam logic [8:0] MAX9 = 9'(MAX_SIDE);

  swr_pkg::coord_t n;
  logic [7:0]      n8, x8, y8, r8;
  logic            win_bad, cell_bad;

  assign n  = ({2'b00, grid_size} > MAX9) ? MAX9[6:0] : grid_size;
  assign n8 = {1'b0, n};
  assign x8 = {1'b0, items.center_row};
  assign y8 = {1'b0, items.center_col};
  assign r8 = {3'b000, items.radius};

  assign win_bad  = (x8 <= r8) || (x8 + r8 > n8) || (y8 <= r8) || (y8 + r8 > n8);
  assign cell_bad = (x8 == 8'd0) || (x8 > n8) || (y8 == 8'd0) || (y8 > n8);

  assign items.ready = !full;
  assign push        = items.valid && !full;

  always_comb begin
    job         = '0;
    job.ctr_row = items.center_row;
    job.ctr_col = items.center_col;
    job.dir     = items.direction;
    unique case (swr_pkg::cmd_t'(items.cmd))
      swr_pkg::CMD_INIT: begin
        if (n == 7'd0) begin
          job.op = swr_pkg::JOB_REPLY;
        end else begin
          job.op     = swr_pkg::JOB_INIT;
          job.row_lo = 7'd1;
          job.row_hi = n;
          job.col_lo = 7'd1;
          job.col_hi = n;
        end
      end
      swr_pkg::CMD_ROTATE: begin
        if (win_bad) begin
          job.op     = swr_pkg::JOB_REPLY;
          job.status = 1'b1;
        end else begin
          job.op     = swr_pkg::JOB_ROTATE;
          job.row_lo = 7'(x8 - r8);
          job.row_hi = 7'(x8 + r8);
          job.col_lo = 7'(y8 - r8);
          job.col_hi = 7'(y8 + r8);
        end
      end
      swr_pkg::CMD_READ: begin
        if (cell_bad) begin
          job.op     = swr_pkg::JOB_REPLY;
          job.status = 1'b1;
        end else begin
          job.op     = swr_pkg::JOB_READ;
          job.row_lo = items.center_row;
          job.row_hi = items.center_row;
          job.col_lo = items.center_col;
          job.col_hi = items.center_col;
        end
      end
      default: begin
        job.op = swr_pkg::JOB_REPLY;
      end
    endcase
  end

endmodule

@@ src/swr_queue.sv @@
// Two-entry job queue between the front end and the sequencer.
`timescale 1ns / 1ps
module swr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  swr_pkg::job_t job_in,
  output logic          full,
  input  logic          pop,
  output swr_pkg::job_t job_out,
  output logic          empty
);

  swr_pkg::job_t entries [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign job_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

@@ src/swr_back.sv @@
// Sequencer: runs jobs against the grid and scratch memories and holds the result word.
`timescale 1ns / 1ps
module swr_back #(
  parameter int MAX_SIDE = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  swr_pkg::job_t job,
  input  logic          empty,
  output logic          pop,
  swr_out_if.source     results
);

  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_COPY,
    S_COPY_DRAIN,
    S_BACK,
    S_BACK_DRAIN,
    S_READ,
    S_READ_WAIT
  } state_t;

  function automatic addr_t cell_addr(swr_pkg::coord_t row, swr_pkg::coord_t col);
    logic [IDX_W+swr_pkg::COORD_W-1:0] r_ext, c_ext;
    r_ext = {{IDX_W{1'b0}}, swr_pkg::coord_t'(row - 7'd1)};
    c_ext = {{IDX_W{1'b0}}, swr_pkg::coord_t'(col - 7'd1)};
    return {r_ext[IDX_W-1:0], c_ext[IDX_W-1:0]};
  endfunction

  state_t          state;
  swr_pkg::job_t   cur;
  swr_pkg::coord_t a, b;
  swr_pkg::cell_t  init_val;
  logic            res_valid;
  swr_pkg::cell_t  res_value;
  logic            res_status;
  logic            scr_pend, grid_pend;
  addr_t           pend_addr;

  swr_pkg::cell_t  grid_mem [DEPTH];
  swr_pkg::cell_t  scr_mem  [DEPTH];
  swr_pkg::cell_t  grid_rdata, scr_rdata;

  addr_t           cur_addr, tgt_addr, grid_waddr;
  swr_pkg::cell_t  grid_wdata;
  logic            grid_we;
  logic            last_col, last_row, out_free;
  logic [7:0]      tr8, tc8;

  assign cur_addr = cell_addr(a, b);
  assign last_col = (b == cur.col_hi);
  assign last_row = (a == cur.row_hi);
  assign out_free = !res_valid || results.ready;
  assign pop      = (state == S_IDLE) && !empty && out_free;

  // quarter turn about the centre, clockwise or the other way
  always_comb begin
    if (!cur.dir) begin
      tr8 = {1'b0, cur.ctr_row} + {1'b0, b} - {1'b0, cur.ctr_col};
      tc8 = {1'b0, cur.ctr_col} + {1'b0, cur.ctr_row} - {1'b0, a};
    end else begin
      tr8 = {1'b0, cur.ctr_row} + {1'b0, cur.ctr_col} - {1'b0, b};
      tc8 = {1'b0, cur.ctr_col} + {1'b0, a} - {1'b0, cur.ctr_row};
    end
  end
  assign tgt_addr = cell_addr(tr8[6:0], tc8[6:0]);

  assign grid_we    = (state == S_INIT) || grid_pend;
  assign grid_waddr = (state == S_INIT) ? cur_addr : pend_addr;
  assign grid_wdata = (state == S_INIT) ? init_val : scr_rdata;

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[grid_waddr] <= grid_wdata;
    end
    grid_rdata <= grid_mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (scr_pend) begin
      scr_mem[pend_addr] <= grid_rdata;
    end
    scr_rdata <= scr_mem[cur_addr];
  end

  assign results.valid      = res_valid;
  assign results.cell_value = res_value;
  assign results.status     = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      scr_pend  <= 1'b0;
      grid_pend <= 1'b0;
    end else begin
      if (res_valid && results.ready) begin
        res_valid <= 1'b0;
      end
      scr_pend  <= (state == S_COPY);
      grid_pend <= (state == S_BACK);
      pend_addr <= (state == S_COPY) ? tgt_addr : cur_addr;

      if (state == S_INIT || state == S_COPY || state == S_BACK) begin
        if (last_col) begin
          b <= cur.col_lo;
          a <= last_row ? cur.row_lo : swr_pkg::coord_t'(a + 7'd1);
        end else begin
          b <= swr_pkg::coord_t'(b + 7'd1);
        end
      end

      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur      <= job;
            a        <= job.row_lo;
            b        <= job.col_lo;
            init_val <= swr_pkg::cell_t'(1);
            unique case (job.op)
              swr_pkg::JOB_INIT:   state <= S_INIT;
              swr_pkg::JOB_ROTATE: state <= S_COPY;
              swr_pkg::JOB_READ:   state <= S_READ;
              swr_pkg::JOB_REPLY: begin
                res_valid  <= 1'b1;
                res_value  <= '0;
                res_status <= job.status;
              end
            endcase
          end
        end
        S_INIT: begin
          init_val <= swr_pkg::cell_t'(init_val + 13'd1);
          if (last_col && last_row) begin
            res_valid  <= 1'b1;
            res_value  <= '0;
            res_status <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_COPY: begin
          if (last_col && last_row) begin
            state <= S_COPY_DRAIN;
          end
        end
        S_COPY_DRAIN: begin
          state <= S_BACK;
        end
        S_BACK: begin
          if (last_col && last_row) begin
            state <= S_BACK_DRAIN;
          end
        end
        S_BACK_DRAIN: begin
          res_valid  <= 1'b1;
          res_value  <= '0;
          res_status <= 1'b0;
          state      <= S_IDLE;
        end
        S_READ: begin
          state <= S_READ_WAIT;
        end
        S_READ_WAIT: begin
          res_valid  <= 1'b1;
          res_value  <= grid_rdata;
          res_status <= 1'b0;
          state      <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/square_window_rotator_top.sv @@
// Top level of the square window rotator: size register, front end, job queue, sequencer.
// Once a job leaves the queue: flagged or unused words reply from idle, a read waits on
// the grid read; init and rotate step one cell per cycle, rotate via the scratch memory.
// Two words can wait in the queue while the sequencer works; one job runs at a time.
// Reset clears control state and sets grid_size to 64; grid contents stay undefined
// until written by init, scratch contents until written by a rotate.
`timescale 1ns / 1ps
module square_window_rotator_top #(
  parameter int MAX_SIDE = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  swr_in_if.sink                      items,
  swr_out_if.source                   results,
  input  logic                        grid_size_we,
  input  logic [swr_pkg::COORD_W-1:0] grid_size_data
);

  swr_pkg::coord_t grid_size;
  swr_pkg::job_t   front_job, queue_job;
  logic            push, full, pop, empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= swr_pkg::GRID_SIZE_RESET;
    end else if (grid_size_we) begin
      grid_size <= grid_size_data;
    end
  end

  swr_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .grid_size (grid_size),
    .items     (items),
    .full      (full),
    .push      (push),
    .job       (front_job)
  );

  swr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .job_in  (front_job),
    .full    (full),
    .pop     (pop),
    .job_out (queue_job),
    .empty   (empty)
  );

  swr_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk     (clk),
    .rst     (rst),
    .job     (queue_job),
    .empty   (empty),
    .pop     (pop),
    .results (results)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the square window rotator: directed table, then random phases.
`timescale 1ns / 1ps
module tb;

  localparam int GRID_MAX = 64;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES = 9;
  localparam int WORDS_PER_PHASE = 8;

  typedef logic [swr_pkg::CMD_W-1:0] cmd_bits_t;

  localparam cmd_bits_t CMD_UNUSED = 2'd3;

  typedef struct {
    cmd_bits_t         cmd;
    swr_pkg::coord_t   row;
    swr_pkg::coord_t   col;
    swr_pkg::radius_t  radius;
    logic              dir;
  } cmd_word_t;

  typedef struct {
    swr_pkg::cell_t value;
    logic           status;
  } reply_t;

  typedef struct {
    cmd_word_t w;
    bit        typed;
    reply_t    reply;
  } step_row_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            grid_size_we = 1'b0;
  swr_pkg::coord_t grid_size_data = swr_pkg::GRID_SIZE_RESET;

  swr_in_if  items_ch ();
  swr_out_if results_ch ();

  square_window_rotator_top #(.MAX_SIDE(GRID_MAX)) dut (
    .clk(clk),
    .rst(rst),
    .items(items_ch),
    .results(results_ch),
    .grid_size_we(grid_size_we),
    .grid_size_data(grid_size_data)
  );

  always #2 clk = ~clk;

  swr_pkg::cell_t  grid_val[1:GRID_MAX][1:GRID_MAX];
  bit              grid_known[1:GRID_MAX][1:GRID_MAX];
  swr_pkg::cell_t  scratch_val[1:GRID_MAX][1:GRID_MAX];
  bit              scratch_known[1:GRID_MAX][1:GRID_MAX];
  swr_pkg::coord_t size_reg = swr_pkg::GRID_SIZE_RESET;

  reply_t replies_due[$];
  int     mismatches = 0;
  int     cycles = 0;
  int     sender_idle = 19;
  int     receiver_idle = 63;

  function automatic int active_side();
    return (size_reg > GRID_MAX) ? GRID_MAX : int'(size_reg);
  endfunction

  // grid update and reply for one command word
  task automatic run_grid_command(input cmd_word_t w, output reply_t rep);
    int n, x, y, r, a, b, tr, tc;
    n = active_side();
    x = int'(w.row);
    y = int'(w.col);
    r = int'(w.radius);
    rep.value = '0;
    rep.status = 1'b0;
    case (w.cmd)
      swr_pkg::CMD_INIT: begin
        for (a = 1; a <= n; a++)
          for (b = 1; b <= n; b++) begin
            grid_val[a][b] = swr_pkg::cell_t'((a - 1) * n + b);
            grid_known[a][b] = 1'b1;
          end
      end
      swr_pkg::CMD_ROTATE: begin
        if (x < r + 1 || x + r > n || y < r + 1 || y + r > n) begin
          rep.status = 1'b1;
        end else begin
          for (a = x - r; a <= x + r; a++)
            for (b = y - r; b <= y + r; b++) begin
              if (w.dir == 1'b0) begin
                tr = x + b - y;
                tc = y + x - a;
              end else begin
                tr = x + y - b;
                tc = y + a - x;
              end
              scratch_val[tr][tc] = grid_val[a][b];
              scratch_known[tr][tc] = grid_known[a][b];
            end
          for (a = x - r; a <= x + r; a++)
            for (b = y - r; b <= y + r; b++) begin
              grid_val[a][b] = scratch_val[a][b];
              grid_known[a][b] = scratch_known[a][b];
            end
        end
      end
      swr_pkg::CMD_READ: begin
        if (x < 1 || x > n || y < 1 || y > n) rep.status = 1'b1;
        else rep.value = grid_val[x][y];
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  function automatic step_row_t step_row(cmd_bits_t c, int row, int col, int r, bit d,
                                         bit typed, int v, bit s);
    step_row_t t;
    t.w.cmd = c;
    t.w.row = swr_pkg::coord_t'(row);
    t.w.col = swr_pkg::coord_t'(col);
    t.w.radius = swr_pkg::radius_t'(r);
    t.w.dir = d;
    t.typed = typed;
    t.reply.value = swr_pkg::cell_t'(v);
    t.reply.status = s;
    return t;
  endfunction

  // random word for the current side; never reads a cell that holds no defined value
  function automatic cmd_word_t pick_word();
    cmd_word_t w;
    int n, roll, r, tries;
    bit found;
    n = active_side();
    roll = $urandom_range(0, 99);
    w.cmd = swr_pkg::CMD_READ;
    w.row = '0;
    w.col = '0;
    w.radius = '0;
    w.dir = 1'($urandom_range(0, 1));
    if (roll < 10) begin
      w.cmd = cmd_bits_t'($urandom_range(0, 3));
      w.row = swr_pkg::coord_t'($urandom_range(0, 127));
      w.col = swr_pkg::coord_t'($urandom_range(0, 127));
      w.radius = swr_pkg::radius_t'($urandom_range(0, 31));
    end else if (roll < 18) begin
      // window just over an edge
      r = $urandom_range(0, 3);
      w.cmd = swr_pkg::CMD_ROTATE;
      w.radius = swr_pkg::radius_t'(r);
      w.row = swr_pkg::coord_t'(($urandom_range(0, 1) != 0) ? r : n - r + 1);
      w.col = swr_pkg::coord_t'($urandom_range(1, (n > 0) ? n : 1));
      if ($urandom_range(0, 1) != 0) begin
        w.col = w.row;
        w.row = swr_pkg::coord_t'($urandom_range(1, (n > 0) ? n : 1));
      end
    end else if (roll < 21) begin
      w.cmd = swr_pkg::CMD_INIT;
    end else if (roll < 60 && n > 0) begin
      r = $urandom_range(0, (n - 1) / 2);
      if (r > 4 && $urandom_range(0, 9) != 0) r = $urandom_range(0, 4);
      w.cmd = swr_pkg::CMD_ROTATE;
      w.radius = swr_pkg::radius_t'(r);
      w.row = swr_pkg::coord_t'($urandom_range(r + 1, n - r));
      w.col = swr_pkg::coord_t'($urandom_range(r + 1, n - r));
    end else begin
      found = 1'b0;
      if (n > 0)
        for (tries = 0; tries < 8 && !found; tries++) begin
          w.row = swr_pkg::coord_t'($urandom_range(1, n));
          w.col = swr_pkg::coord_t'($urandom_range(1, n));
          found = grid_known[w.row][w.col];
        end
      if (!found) w.row = swr_pkg::coord_t'(n + 1);
    end
    if (w.cmd == swr_pkg::CMD_READ && w.row >= 1 && w.row <= n && w.col >= 1 && w.col <= n &&
        !grid_known[w.row][w.col])
      w.row = '0;
    return w;
  endfunction

  // present one word, hold until accepted, then log its reply
  task automatic send_word(input cmd_word_t w, input bit typed, input reply_t typed_reply);
    reply_t rep;
    while ($urandom_range(0, 99) < sender_idle) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.cmd <= w.cmd;
    items_ch.center_row <= w.row;
    items_ch.center_col <= w.col;
    items_ch.radius <= w.radius;
    items_ch.direction <= w.dir;
    @(posedge clk);
    while (items_ch.ready !== 1'b1) @(posedge clk);
    run_grid_command(w, rep);
    replies_due.push_back(typed ? typed_reply : rep);
  endtask

  task automatic set_grid_size(input int v);
    items_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    grid_size_we <= 1'b1;
    grid_size_data <= swr_pkg::coord_t'(v);
    @(posedge clk);
    grid_size_we <= 1'b0;
    size_reg = swr_pkg::coord_t'(v);
  endtask

  always @(posedge clk) begin
    reply_t due;
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      if (results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word value=%0d status=%0b",
                                    results_ch.cell_value, results_ch.status));
        end else begin
          due = replies_due.pop_front();
          if (results_ch.cell_value !== due.value)
            report_mismatch($sformatf("cell_value %0d, want %0d",
                                      results_ch.cell_value, due.value));
          if (results_ch.status !== due.status)
            report_mismatch($sformatf("status %0b, want %0b", results_ch.status, due.status));
        end
      end
      results_ch.ready <= ($urandom_range(0, 99) >= receiver_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[square_window_rotator_top] ERROR");
      $finish;
    end
  end

  initial begin
    step_row_t steps[$];
    reply_t    none;
    int        phase_size[PHASES] = '{5, 1, 0, 12, 127, 9, 64, 3, 20};
    bit        phase_init[PHASES] = '{1, 1, 1, 1, 1, 0, 0, 1, 0};
    int        p, k, sent;

    items_ch.valid = 1'b0;
    items_ch.cmd = swr_pkg::CMD_INIT;
    items_ch.center_row = '0;
    items_ch.center_col = '0;
    items_ch.radius = '0;
    items_ch.direction = 1'b0;
    none.value = '0;
    none.status = 1'b0;

    // grid side at its reset value of 64
    steps.push_back(step_row(swr_pkg::CMD_READ,     0,   1,  0, 0, 1, 0, 1));
    steps.push_back(step_row(swr_pkg::CMD_ROTATE,   1,   1,  1, 0, 1, 0, 1));
    steps.push_back(step_row(CMD_UNUSED,          127, 127, 31, 1, 1, 0, 0));
    steps.push_back(step_row(swr_pkg::CMD_INIT,     0,   0,  0, 0, 1, 0, 0));
    steps.push_back(step_row(swr_pkg::CMD_READ,     1,   1,  0, 0, 1, 1, 0));
    steps.push_back(step_row(swr_pkg::CMD_READ,    64,  64,  0, 0, 1, 4096, 0));
    steps.push_back(step_row(swr_pkg::CMD_READ,     1,  64,  0, 0, 1, 64, 0));
    steps.push_back(step_row(swr_pkg::CMD_READ,    64,   1,  0, 0, 1, 4033, 0));
    steps.push_back(step_row(swr_pkg::CMD_READ,    65,   1,  0, 0, 1, 0, 1));
    steps.push_back(step_row(swr_pkg::CMD_READ,     1,  65,  0, 0, 1, 0, 1));
    steps.push_back(step_row(swr_pkg::CMD_READ,   127, 127,  0, 1, 1, 0, 1));
    steps.push_back(step_row(swr_pkg::CMD_ROTATE,   2,   2,  1, 0, 0, 0, 0));
    steps.push_back(step_row(swr_pkg::CMD_READ,     1,   1,  0, 0, 0, 0, 0));
    steps.push_back(step_row(swr_pkg::CMD_READ,     1,   3,  0, 0, 0, 0, 0));
    steps.push_back(step_row(swr_pkg::CMD_ROTATE,   2,   2,  1, 1, 0, 0, 0));
    steps.push_back(step_row(swr_pkg::CMD_READ,     1,   3,  0, 0, 0, 0, 0));
    steps.push_back(step_row(swr_pkg::CMD_ROTATE,  32,  32, 31, 1, 0, 0, 0));
    steps.push_back(step_row(swr_pkg::CMD_READ,     1,   1,  0, 0, 0, 0, 0));
    steps.push_back(step_row(swr_pkg::CMD_ROTATE,  33,  33, 31, 0, 0, 0, 0));
    steps.push_back(step_row(swr_pkg::CMD_READ,    64,  64,  0, 0, 0, 0, 0));
    steps.push_back(step_row(swr_pkg::CMD_ROTATE,  64,  64,  0, 1, 0, 0, 0));
    steps.push_back(step_row(swr_pkg::CMD_ROTATE,  64,  64,  1, 0, 1, 0, 1));
    steps.push_back(step_row(swr_pkg::CMD_ROTATE,   0,   5,  0, 0, 1, 0, 1));
    steps.push_back(step_row(swr_pkg::CMD_ROTATE, 127, 127, 31, 1, 1, 0, 1));
    steps.push_back(step_row(swr_pkg::CMD_READ,    33,   2,  0, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (steps[i]) send_word(steps[i].w, steps[i].typed, steps[i].reply);

    sent = 0;
    for (p = 0; p < PHASES; p++) begin
      set_grid_size(phase_size[p]);
      if (phase_init[p]) begin
        cmd_word_t w;
        w.cmd = swr_pkg::CMD_INIT;
        w.row = '0;
        w.col = '0;
        w.radius = '0;
        w.dir = 1'b0;
        send_word(w, 1'b0, none);
      end
      for (k = 0; k < WORDS_PER_PHASE; k++) begin
        if (sent == PHASES * WORDS_PER_PHASE / 3) begin
          sender_idle = 63;
          receiver_idle = 19;
        end else if (sent == 2 * PHASES * WORDS_PER_PHASE / 3) begin
          sender_idle = 0;
          receiver_idle = 0;
        end
        send_word(pick_word(), 1'b0, none);
        sent++;
      end
    end

    items_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("[square_window_rotator_top] OK");
    else $display("[square_window_rotator_top] ERROR");
    $finish;
  end

endmodule
